### sv/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// types, codes and constants shared by the priority task scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pts_pkg;

    localparam int MAX_TASKS      = 8;
    localparam int PRIORITY_COUNT = 32;
    localparam int TASK_W         = 4;
    localparam int TIDX_W         = 3;
    localparam int PRIO_W         = 5;
    localparam int KIND_W         = 3;
    localparam int STAT_W         = 3;
    localparam int REASON_W       = 2;
    localparam int TICK_W         = 32;
    localparam int STACK_W        = 16;
    localparam int RSTAT_W        = 2;

    localparam logic [TASK_W-1:0] IDLE_ID  = TASK_W'(MAX_TASKS);
    localparam logic [TASK_W-1:0] NO_TASK  = TASK_W'(MAX_TASKS + 1);
    localparam logic [TASK_W-1:0] END_LINK = TASK_W'(MAX_TASKS);

    localparam logic [STACK_W-1:0] MIN_STACK_RESET = 16'd64;

    localparam logic [STAT_W-1:0] ST_FREE   = 3'd0;
    localparam logic [STAT_W-1:0] ST_READY  = 3'd1;
    localparam logic [STAT_W-1:0] ST_HELD   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DELAY0 = 3'd3;
    localparam logic [STAT_W-1:0] ST_DELAY1 = 3'd4;
    localparam logic [STAT_W-1:0] ST_SUSP   = 3'd5;

    localparam logic [KIND_W-1:0] K_START   = 3'd0;
    localparam logic [KIND_W-1:0] K_SWITCH  = 3'd1;
    localparam logic [KIND_W-1:0] K_CREATE  = 3'd2;
    localparam logic [KIND_W-1:0] K_BLOCK   = 3'd3;
    localparam logic [KIND_W-1:0] K_UNBLOCK = 3'd4;
    localparam logic [KIND_W-1:0] K_TICK    = 3'd5;
    localparam logic [KIND_W-1:0] K_CLEAR   = 3'd6;

    localparam logic [RSTAT_W-1:0] RS_OK       = 2'd0;
    localparam logic [RSTAT_W-1:0] RS_INVALID  = 2'd1;
    localparam logic [RSTAT_W-1:0] RS_STACK    = 2'd2;
    localparam logic [RSTAT_W-1:0] RS_LIMIT    = 2'd3;

    localparam logic [REASON_W-1:0] REASON_NONE    = 2'd0;
    localparam logic [REASON_W-1:0] REASON_TIMEOUT = 2'd1;

    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [STAT_W-1:0]   status;
        logic [TICK_W-1:0]   wake;
        logic [REASON_W-1:0] reason;
        logic [TASK_W-1:0]   link;
    } task_rec_t;

    localparam int TREC_W = $bits(task_rec_t);

    typedef struct packed {
        logic [TASK_W-1:0] head;
        logic [TASK_W-1:0] tail;
    } ht_t;

    localparam int HT_W = $bits(ht_t);

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [7:0]          priority_req;
        logic [STACK_W-1:0]  stack_words;
        logic                stack_aligned;
        logic                args_valid;
        logic [TICK_W-1:0]   wake_tick;
        logic                infinite;
        logic [TIDX_W-1:0]   target_task;
        logic [REASON_W-1:0] wake_reason;
    } cmd_t;

    typedef enum logic [20:0] {
        S_IDLE  = 21'h000001,
        S_DISP  = 21'h000002,
        S_TRD   = 21'h000004,
        S_SWSEL = 21'h000008,
        S_PUSH0 = 21'h000010,
        S_PUSH1 = 21'h000020,
        S_PUSH2 = 21'h000040,
        S_POP0  = 21'h000080,
        S_POP1  = 21'h000100,
        S_POP2  = 21'h000200,
        S_INS0  = 21'h000400,
        S_INS1  = 21'h000800,
        S_INSF0 = 21'h001000,
        S_INSF1 = 21'h002000,
        S_REM0  = 21'h004000,
        S_REM1  = 21'h008000,
        S_WRAP0 = 21'h010000,
        S_WRAP1 = 21'h020000,
        S_WAKE0 = 21'h040000,
        S_WAKE1 = 21'h080000,
        S_DONE  = 21'h100000
    } state_t;

endpackage

### sv/pts_cmd_if.sv
// ----------------------------------------------------------------------------
// pts_cmd_if
// command item channel of the priority task scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pts_cmd_if;
    logic                                         valid;
    logic                                         ready;
    logic [pts_pkg::KIND_W-1:0]                   kind;
    logic [7:0]                                   priority_req;
    logic [pts_pkg::STACK_W-1:0]                  stack_words;
    logic                                         stack_aligned;
    logic                                         args_valid;
    logic [pts_pkg::TICK_W-1:0]                   wake_tick;
    logic                                         infinite;
    logic [pts_pkg::TIDX_W-1:0]                   target_task;
    logic [pts_pkg::REASON_W-1:0]                 wake_reason;

    modport source (
        output valid, kind, priority_req, stack_words, stack_aligned, args_valid,
               wake_tick, infinite, target_task, wake_reason,
        input  ready
    );
    modport sink (
        input  valid, kind, priority_req, stack_words, stack_aligned, args_valid,
               wake_tick, infinite, target_task, wake_reason,
        output ready
    );
endinterface

### sv/pts_res_if.sv
// ----------------------------------------------------------------------------
// pts_res_if
// result item channel of the priority task scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pts_res_if;
    logic                            valid;
    logic                            ready;
    logic [pts_pkg::RSTAT_W-1:0]     status;
    logic [pts_pkg::TASK_W-1:0]      chosen_task;
    logic                            chosen_valid;
    logic                            switch_request;
    logic [pts_pkg::TICK_W-1:0]      tick_now;
    logic [pts_pkg::REASON_W-1:0]    current_wait_reason;
    logic [pts_pkg::PRIO_W-1:0]      current_priority;

    modport source (
        output valid, status, chosen_task, chosen_valid, switch_request, tick_now,
               current_wait_reason, current_priority,
        input  ready
    );
    modport sink (
        input  valid, status, chosen_task, chosen_valid, switch_request, tick_now,
               current_wait_reason, current_priority,
        output ready
    );
endinterface

### sv/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/priority_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler_top
// items are taken one at a time; the walks of the delay lists and the ready
// queue updates go through the single read port of the task ram
// reset: control registers clear at once, task ram entries count as unused
// through valid flags, so no clearing pass is needed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_task_scheduler_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pts_pkg::STACK_W-1:0]   cfg_wr_data,
    pts_cmd_if.sink                       cmd,
    pts_res_if.source                     res
);

    localparam int TW = pts_pkg::TASK_W;
    localparam int IW = pts_pkg::TIDX_W;
    localparam int PW = pts_pkg::PRIO_W;

    pts_pkg::state_t     state_reg, state_next, ret_reg, ret_next;
    pts_pkg::cmd_t       cmd_reg, cmd_next;
    pts_pkg::task_rec_t  trec_reg, trec_next, prevrec_reg, prevrec_next;
    pts_pkg::ht_t        ht_reg, ht_next;
    logic [PW-1:0]       p_reg, p_next;
    logic [TW-1:0]       t_reg, t_next, cur_reg, cur_next, prev_reg, prev_next;
    logic                q_reg, q_next;
    logic [pts_pkg::PRIORITY_COUNT-1:0] mask_reg, mask_next;
    logic [1:0][TW-1:0]  heads_reg, heads_next;
    logic                swap_reg, swap_next;
    logic [TW-1:0]       run_reg, run_next;
    logic [PW-1:0]       run_prio_reg, run_prio_next;
    logic [pts_pkg::REASON_W-1:0] run_reason_reg, run_reason_next;
    logic [pts_pkg::TICK_W-1:0]   tick_reg, tick_next;
    logic [pts_pkg::MAX_TASKS-1:0] vld_reg, vld_next;
    logic [pts_pkg::STACK_W-1:0]  min_stack_reg;
    logic [pts_pkg::RSTAT_W-1:0]  rstat_reg, rstat_next;
    logic                created_reg, created_next, refused_reg, refused_next;
    logic                swc_reg, swc_next;

    logic                         res_valid_reg, res_valid_next;
    logic [pts_pkg::RSTAT_W-1:0]  res_status_reg, res_status_next;
    logic [TW-1:0]                res_task_reg, res_task_next;
    logic                         res_cvalid_reg, res_cvalid_next;
    logic                         res_sw_reg, res_sw_next;
    logic [pts_pkg::TICK_W-1:0]   res_tick_reg, res_tick_next;
    logic [pts_pkg::REASON_W-1:0] res_reason_reg, res_reason_next;
    logic [PW-1:0]                res_prio_reg, res_prio_next;

    // task ram and ready queue ram ports
    logic                          tw_en;
    logic [IW-1:0]                 tw_addr, tr_addr;
    pts_pkg::task_rec_t            tw_data, tr_data;
    logic                          rw_en;
    logic [PW-1:0]                 rw_addr, rr_addr;
    pts_pkg::ht_t                  rw_data, rr_data;

    logic [PW-1:0]                 top_prio;
    logic [IW-1:0]                 free_slot;
    pts_pkg::task_rec_t            rec_in, r;
    logic                          cmd_acc, res_free;

    pts_ram #(
        .WIDTH (pts_pkg::TREC_W),
        .DEPTH (pts_pkg::MAX_TASKS)
    ) u_task_ram (
        .clk     (clk),
        .wr_en   (tw_en),
        .wr_addr (tw_addr),
        .wr_data (tw_data),
        .rd_addr (tr_addr),
        .rd_data (tr_data)
    );

    pts_ram #(
        .WIDTH (pts_pkg::HT_W),
        .DEPTH (pts_pkg::PRIORITY_COUNT)
    ) u_ready_ram (
        .clk     (clk),
        .wr_en   (rw_en),
        .wr_addr (rw_addr),
        .wr_data (rw_data),
        .rd_addr (rr_addr),
        .rd_data (rr_data)
    );

    always_comb
    begin
        top_prio = '0;
        for (int i = 0; i < pts_pkg::PRIORITY_COUNT; i++)
        begin
            if (mask_reg[i])
            begin
                top_prio = PW'(i);
            end
        end
    end

    always_comb
    begin
        free_slot = '0;
        for (int i = pts_pkg::MAX_TASKS - 1; i >= 0; i--)
        begin
            if (!vld_reg[i])
            begin
                free_slot = IW'(i);
            end
        end
    end

    // unused entries read as free, priority and reason zero
    always_comb
    begin
        rec_in = tr_data;
        if (!vld_reg[t_reg[IW-1:0]])
        begin
            rec_in        = '0;
            rec_in.status = pts_pkg::ST_FREE;
            rec_in.link   = pts_pkg::END_LINK;
        end
    end

    assign cmd_acc   = cmd.valid && cmd.ready;
    assign res_free  = !res_valid_reg || res.ready;
    assign cmd.ready = (state_reg == pts_pkg::S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        cmd_next        = cmd_reg;
        trec_next       = trec_reg;
        prevrec_next    = prevrec_reg;
        ht_next         = ht_reg;
        p_next          = p_reg;
        t_next          = t_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        q_next          = q_reg;
        mask_next       = mask_reg;
        heads_next      = heads_reg;
        swap_next       = swap_reg;
        run_next        = run_reg;
        run_prio_next   = run_prio_reg;
        run_reason_next = run_reason_reg;
        tick_next       = tick_reg;
        vld_next        = vld_reg;
        rstat_next      = rstat_reg;
        created_next    = created_reg;
        refused_next    = refused_reg;
        swc_next        = swc_reg;
        res_valid_next  = res_valid_reg && !res.ready;
        res_status_next = res_status_reg;
        res_task_next   = res_task_reg;
        res_cvalid_next = res_cvalid_reg;
        res_sw_next     = res_sw_reg;
        res_tick_next   = res_tick_reg;
        res_reason_next = res_reason_reg;
        res_prio_next   = res_prio_reg;
        tw_en           = 1'b0;
        tw_addr         = '0;
        tw_data         = trec_reg;
        tr_addr         = '0;
        rw_en           = 1'b0;
        rw_addr         = '0;
        rw_data         = ht_reg;
        rr_addr         = '0;
        r               = trec_reg;

        case (state_reg)
            pts_pkg::S_IDLE:
            begin
                if (cmd_acc)
                begin
                    cmd_next.kind          = cmd.kind;
                    cmd_next.priority_req  = cmd.priority_req;
                    cmd_next.stack_words   = cmd.stack_words;
                    cmd_next.stack_aligned = cmd.stack_aligned;
                    cmd_next.args_valid    = cmd.args_valid;
                    cmd_next.wake_tick     = cmd.wake_tick;
                    cmd_next.infinite      = cmd.infinite;
                    cmd_next.target_task   = cmd.target_task;
                    cmd_next.wake_reason   = cmd.wake_reason;
                    rstat_next             = pts_pkg::RS_OK;
                    created_next           = 1'b0;
                    refused_next           = 1'b0;
                    swc_next               = 1'b0;
                    state_next             = pts_pkg::S_DISP;
                end
            end

            pts_pkg::S_DISP:
            begin
                state_next = pts_pkg::S_DONE;
                case (cmd_reg.kind)
                    pts_pkg::K_START:
                    begin
                        if (run_reg != pts_pkg::NO_TASK || mask_reg == '0)
                        begin
                            refused_next = 1'b1;
                        end
                        else
                        begin
                            state_next = pts_pkg::S_POP0;
                        end
                    end
                    pts_pkg::K_SWITCH:
                    begin
                        if (run_reg == pts_pkg::NO_TASK)
                        begin
                            refused_next = 1'b1;
                        end
                        else if (run_reg < TW'(pts_pkg::MAX_TASKS))
                        begin
                            tr_addr    = run_reg[IW-1:0];
                            t_next     = run_reg;
                            state_next = pts_pkg::S_TRD;
                        end
                        else
                        begin
                            state_next = pts_pkg::S_SWSEL;
                        end
                    end
                    pts_pkg::K_CREATE:
                    begin
                        if (!cmd_reg.args_valid || !cmd_reg.stack_aligned ||
                            cmd_reg.priority_req >= 8'(pts_pkg::PRIORITY_COUNT))
                        begin
                            rstat_next = pts_pkg::RS_INVALID;
                        end
                        else if (cmd_reg.stack_words < min_stack_reg)
                        begin
                            rstat_next = pts_pkg::RS_STACK;
                        end
                        else if (&vld_reg)
                        begin
                            rstat_next = pts_pkg::RS_LIMIT;
                        end
                        else
                        begin
                            t_next              = {1'b0, free_slot};
                            trec_next.prio      = cmd_reg.priority_req[PW-1:0];
                            trec_next.status    = pts_pkg::ST_FREE;
                            trec_next.wake      = cmd_reg.wake_tick;
                            trec_next.reason    = pts_pkg::REASON_NONE;
                            trec_next.link      = pts_pkg::END_LINK;
                            vld_next[free_slot] = 1'b1;
                            created_next        = 1'b1;
                            swc_next            = (run_reg != pts_pkg::NO_TASK) &&
                                (cmd_reg.priority_req > {3'b000, run_prio_reg});
                            ret_next            = pts_pkg::S_DONE;
                            state_next          = pts_pkg::S_PUSH0;
                        end
                    end
                    pts_pkg::K_BLOCK:
                    begin
                        if (run_reg < TW'(pts_pkg::MAX_TASKS))
                        begin
                            tr_addr    = run_reg[IW-1:0];
                            t_next     = run_reg;
                            state_next = pts_pkg::S_TRD;
                        end
                    end
                    pts_pkg::K_UNBLOCK:
                    begin
                        if ({1'b0, cmd_reg.target_task} < TW'(pts_pkg::MAX_TASKS))
                        begin
                            tr_addr    = cmd_reg.target_task;
                            t_next     = {1'b0, cmd_reg.target_task};
                            state_next = pts_pkg::S_TRD;
                        end
                    end
                    pts_pkg::K_TICK:
                    begin
                        tick_next = tick_reg + 32'd1;
                        if (tick_next == '0)
                        begin
                            t_next     = heads_reg[swap_reg];
                            state_next = pts_pkg::S_WRAP0;
                        end
                        else
                        begin
                            state_next = pts_pkg::S_WAKE0;
                        end
                    end
                    pts_pkg::K_CLEAR:
                    begin
                        if (run_reg < TW'(pts_pkg::MAX_TASKS))
                        begin
                            run_reason_next = pts_pkg::REASON_NONE;
                            tr_addr         = run_reg[IW-1:0];
                            t_next          = run_reg;
                            state_next      = pts_pkg::S_TRD;
                        end
                    end
                    default:
                    begin
                        state_next = pts_pkg::S_DONE;
                    end
                endcase
            end

            pts_pkg::S_TRD:
            begin
                r          = rec_in;
                trec_next  = rec_in;
                state_next = pts_pkg::S_DONE;
                case (cmd_reg.kind)
                    pts_pkg::K_SWITCH:
                    begin
                        if (rec_in.status == pts_pkg::ST_HELD)
                        begin
                            ret_next   = pts_pkg::S_SWSEL;
                            state_next = pts_pkg::S_PUSH0;
                        end
                        else
                        begin
                            state_next = pts_pkg::S_SWSEL;
                        end
                    end
                    pts_pkg::K_BLOCK:
                    begin
                        if (rec_in.status == pts_pkg::ST_HELD)
                        begin
                            r.wake    = cmd_reg.wake_tick;
                            trec_next = r;
                            if (cmd_reg.infinite)
                            begin
                                r.status = pts_pkg::ST_SUSP;
                                tw_en    = 1'b1;
                                tw_addr  = t_reg[IW-1:0];
                                tw_data  = r;
                            end
                            else
                            begin
                                q_next     = (cmd_reg.wake_tick < tick_reg) ? !swap_reg
                                                                            : swap_reg;
                                cur_next   = heads_reg[q_next];
                                prev_next  = pts_pkg::END_LINK;
                                state_next = pts_pkg::S_INS0;
                            end
                        end
                    end
                    pts_pkg::K_UNBLOCK:
                    begin
                        r.reason  = cmd_reg.wake_reason;
                        trec_next = r;
                        ret_next  = pts_pkg::S_DONE;
                        if (rec_in.status == pts_pkg::ST_DELAY0 ||
                            rec_in.status == pts_pkg::ST_DELAY1)
                        begin
                            q_next     = (rec_in.status == pts_pkg::ST_DELAY1);
                            cur_next   = heads_reg[q_next];
                            prev_next  = pts_pkg::END_LINK;
                            state_next = pts_pkg::S_REM0;
                        end
                        else if (rec_in.status == pts_pkg::ST_SUSP)
                        begin
                            state_next = pts_pkg::S_PUSH0;
                        end
                    end
                    pts_pkg::K_CLEAR:
                    begin
                        r.reason = pts_pkg::REASON_NONE;
                        tw_en    = 1'b1;
                        tw_addr  = t_reg[IW-1:0];
                        tw_data  = r;
                    end
                    default:
                    begin
                        state_next = pts_pkg::S_DONE;
                    end
                endcase
            end

            pts_pkg::S_SWSEL:
            begin
                if (mask_reg == '0)
                begin
                    run_next        = pts_pkg::IDLE_ID;
                    run_prio_next   = '0;
                    run_reason_next = pts_pkg::REASON_NONE;
                    state_next      = pts_pkg::S_DONE;
                end
                else
                begin
                    state_next = pts_pkg::S_POP0;
                end
            end

            pts_pkg::S_PUSH0:
            begin
                r          = trec_reg;
                r.link     = pts_pkg::END_LINK;
                r.status   = pts_pkg::ST_READY;
                trec_next  = r;
                tw_en      = 1'b1;
                tw_addr    = t_reg[IW-1:0];
                tw_data    = r;
                p_next     = trec_reg.prio;
                if (t_reg == run_reg)
                begin
                    run_reason_next = trec_reg.reason;
                end
                if (!mask_reg[trec_reg.prio])
                begin
                    rw_en                     = 1'b1;
                    rw_addr                   = trec_reg.prio;
                    rw_data.head              = t_reg;
                    rw_data.tail              = t_reg;
                    mask_next[trec_reg.prio]  = 1'b1;
                    state_next                = ret_reg;
                end
                else
                begin
                    rr_addr    = trec_reg.prio;
                    state_next = pts_pkg::S_PUSH1;
                end
            end

            pts_pkg::S_PUSH1:
            begin
                ht_next      = rr_data;
                rw_en        = 1'b1;
                rw_addr      = p_reg;
                rw_data.head = rr_data.head;
                rw_data.tail = t_reg;
                tr_addr      = rr_data.tail[IW-1:0];
                prev_next    = rr_data.tail;
                state_next   = pts_pkg::S_PUSH2;
            end

            pts_pkg::S_PUSH2:
            begin
                r          = tr_data;
                r.link     = t_reg;
                tw_en      = 1'b1;
                tw_addr    = prev_reg[IW-1:0];
                tw_data    = r;
                state_next = ret_reg;
            end

            pts_pkg::S_POP0:
            begin
                p_next     = top_prio;
                rr_addr    = top_prio;
                state_next = pts_pkg::S_POP1;
            end

            pts_pkg::S_POP1:
            begin
                ht_next    = rr_data;
                tr_addr    = rr_data.head[IW-1:0];
                t_next     = rr_data.head;
                state_next = pts_pkg::S_POP2;
            end

            pts_pkg::S_POP2:
            begin
                r = tr_data;
                if (tr_data.link == pts_pkg::END_LINK)
                begin
                    mask_next[p_reg] = 1'b0;
                end
                else
                begin
                    rw_en        = 1'b1;
                    rw_addr      = p_reg;
                    rw_data.head = tr_data.link;
                    rw_data.tail = ht_reg.tail;
                end
                r.status        = pts_pkg::ST_HELD;
                tw_en           = 1'b1;
                tw_addr         = t_reg[IW-1:0];
                tw_data         = r;
                run_next        = t_reg;
                run_prio_next   = tr_data.prio;
                run_reason_next = tr_data.reason;
                state_next      = pts_pkg::S_DONE;
            end

            pts_pkg::S_INS0:
            begin
                if (cur_reg == pts_pkg::END_LINK)
                begin
                    state_next = pts_pkg::S_INSF0;
                end
                else
                begin
                    tr_addr    = cur_reg[IW-1:0];
                    state_next = pts_pkg::S_INS1;
                end
            end

            pts_pkg::S_INS1:
            begin
                if (tr_data.wake <= trec_reg.wake)
                begin
                    prev_next    = cur_reg;
                    prevrec_next = tr_data;
                    cur_next     = tr_data.link;
                    state_next   = pts_pkg::S_INS0;
                end
                else
                begin
                    state_next = pts_pkg::S_INSF0;
                end
            end

            pts_pkg::S_INSF0:
            begin
                r        = trec_reg;
                r.link   = cur_reg;
                r.status = q_reg ? pts_pkg::ST_DELAY1 : pts_pkg::ST_DELAY0;
                tw_en    = 1'b1;
                tw_addr  = t_reg[IW-1:0];
                tw_data  = r;
                if (prev_reg == pts_pkg::END_LINK)
                begin
                    heads_next[q_reg] = t_reg;
                    state_next        = pts_pkg::S_DONE;
                end
                else
                begin
                    state_next = pts_pkg::S_INSF1;
                end
            end

            pts_pkg::S_INSF1:
            begin
                r          = prevrec_reg;
                r.link     = t_reg;
                tw_en      = 1'b1;
                tw_addr    = prev_reg[IW-1:0];
                tw_data    = r;
                state_next = pts_pkg::S_DONE;
            end

            pts_pkg::S_REM0:
            begin
                if (cur_reg == pts_pkg::END_LINK)
                begin
                    state_next = pts_pkg::S_PUSH0;
                end
                else if (cur_reg == t_reg)
                begin
                    if (prev_reg == pts_pkg::END_LINK)
                    begin
                        heads_next[q_reg] = trec_reg.link;
                    end
                    else
                    begin
                        r       = prevrec_reg;
                        r.link  = trec_reg.link;
                        tw_en   = 1'b1;
                        tw_addr = prev_reg[IW-1:0];
                        tw_data = r;
                    end
                    state_next = pts_pkg::S_PUSH0;
                end
                else
                begin
                    tr_addr    = cur_reg[IW-1:0];
                    state_next = pts_pkg::S_REM1;
                end
            end

            pts_pkg::S_REM1:
            begin
                prev_next    = cur_reg;
                prevrec_next = tr_data;
                cur_next     = tr_data.link;
                state_next   = pts_pkg::S_REM0;
            end

            // wrap: tasks left in the old list are dropped as held
            pts_pkg::S_WRAP0:
            begin
                if (t_reg == pts_pkg::END_LINK)
                begin
                    heads_next[swap_reg] = pts_pkg::END_LINK;
                    swap_next            = !swap_reg;
                    state_next           = pts_pkg::S_WAKE0;
                end
                else
                begin
                    tr_addr    = t_reg[IW-1:0];
                    state_next = pts_pkg::S_WRAP1;
                end
            end

            pts_pkg::S_WRAP1:
            begin
                r          = tr_data;
                r.status   = pts_pkg::ST_HELD;
                tw_en      = 1'b1;
                tw_addr    = t_reg[IW-1:0];
                tw_data    = r;
                t_next     = tr_data.link;
                state_next = pts_pkg::S_WRAP0;
            end

            pts_pkg::S_WAKE0:
            begin
                if (heads_reg[swap_reg] == pts_pkg::END_LINK)
                begin
                    state_next = pts_pkg::S_DONE;
                end
                else
                begin
                    tr_addr    = heads_reg[swap_reg][IW-1:0];
                    t_next     = heads_reg[swap_reg];
                    state_next = pts_pkg::S_WAKE1;
                end
            end

            pts_pkg::S_WAKE1:
            begin
                if (tr_data.wake <= tick_reg)
                begin
                    r          = tr_data;
                    r.reason   = pts_pkg::REASON_TIMEOUT;
                    trec_next  = r;
                    q_next     = swap_reg;
                    cur_next   = t_reg;
                    prev_next  = pts_pkg::END_LINK;
                    ret_next   = pts_pkg::S_WAKE0;
                    state_next = pts_pkg::S_REM0;
                end
                else
                begin
                    state_next = pts_pkg::S_DONE;
                end
            end

            pts_pkg::S_DONE:
            begin
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = rstat_reg;
                    if (created_reg)
                    begin
                        res_task_next   = t_reg;
                        res_cvalid_next = 1'b1;
                    end
                    else if (refused_reg || run_reg == pts_pkg::NO_TASK)
                    begin
                        res_task_next   = '0;
                        res_cvalid_next = 1'b0;
                    end
                    else
                    begin
                        res_task_next   = run_reg;
                        res_cvalid_next = 1'b1;
                    end
                    if (cmd_reg.kind == pts_pkg::K_TICK)
                    begin
                        res_sw_next = |(mask_reg >> run_prio_reg);
                    end
                    else
                    begin
                        res_sw_next = swc_reg;
                    end
                    res_tick_next   = tick_reg;
                    res_reason_next = run_reason_reg;
                    res_prio_next   = run_prio_reg;
                    state_next      = pts_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = pts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pts_pkg::S_IDLE;
            ret_reg        <= pts_pkg::S_DONE;
            t_reg          <= '0;
            cur_reg        <= pts_pkg::END_LINK;
            prev_reg       <= pts_pkg::END_LINK;
            q_reg          <= 1'b0;
            mask_reg       <= '0;
            heads_reg      <= {pts_pkg::END_LINK, pts_pkg::END_LINK};
            swap_reg       <= 1'b0;
            run_reg        <= pts_pkg::NO_TASK;
            run_prio_reg   <= '0;
            run_reason_reg <= pts_pkg::REASON_NONE;
            tick_reg       <= '0;
            vld_reg        <= '0;
            min_stack_reg  <= pts_pkg::MIN_STACK_RESET;
            rstat_reg      <= pts_pkg::RS_OK;
            created_reg    <= 1'b0;
            refused_reg    <= 1'b0;
            swc_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            t_reg          <= t_next;
            cur_reg        <= cur_next;
            prev_reg       <= prev_next;
            q_reg          <= q_next;
            mask_reg       <= mask_next;
            heads_reg      <= heads_next;
            swap_reg       <= swap_next;
            run_reg        <= run_next;
            run_prio_reg   <= run_prio_next;
            run_reason_reg <= run_reason_next;
            tick_reg       <= tick_next;
            vld_reg        <= vld_next;
            if (cfg_wr_en)
            begin
                min_stack_reg <= cfg_wr_data;
            end
            rstat_reg      <= rstat_next;
            created_reg    <= created_next;
            refused_reg    <= refused_next;
            swc_reg        <= swc_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        trec_reg       <= trec_next;
        prevrec_reg    <= prevrec_next;
        ht_reg         <= ht_next;
        p_reg          <= p_next;
        res_status_reg <= res_status_next;
        res_task_reg   <= res_task_next;
        res_cvalid_reg <= res_cvalid_next;
        res_sw_reg     <= res_sw_next;
        res_tick_reg   <= res_tick_next;
        res_reason_reg <= res_reason_next;
        res_prio_reg   <= res_prio_next;
    end

    assign res.valid               = res_valid_reg;
    assign res.status              = res_status_reg;
    assign res.chosen_task         = res_task_reg;
    assign res.chosen_valid        = res_cvalid_reg;
    assign res.switch_request      = res_sw_reg;
    assign res.tick_now            = res_tick_reg;
    assign res.current_wait_reason = res_reason_reg;
    assign res.current_priority    = res_prio_reg;

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// checks the priority task scheduler against a behavioural predictor; items
// are driven with random gaps, results are taken with random stalls and
// compared field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import pts_pkg::*;

    typedef struct packed {
        logic [RSTAT_W-1:0]  status;
        logic [TASK_W-1:0]   chosen_task;
        logic                chosen_valid;
        logic                switch_request;
        logic [TICK_W-1:0]   tick_now;
        logic [REASON_W-1:0] wait_reason;
        logic [PRIO_W-1:0]   prio;
    } sched_res_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [STACK_W-1:0] cfg_wr_data;

    pts_cmd_if cmd ();
    pts_res_if res ();

    priority_task_scheduler_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .res         (res)
    );

    // predictor state
    logic [STACK_W-1:0]  min_stack;
    logic [PRIO_W-1:0]   t_prio   [MAX_TASKS];
    logic [STAT_W-1:0]   t_stat   [MAX_TASKS];
    logic [TICK_W-1:0]   t_wake   [MAX_TASKS];
    logic [REASON_W-1:0] t_reason [MAX_TASKS];
    logic [TASK_W-1:0]   t_link   [MAX_TASKS];
    logic [TASK_W-1:0]   rq_head  [PRIORITY_COUNT];
    logic [TASK_W-1:0]   rq_tail  [PRIORITY_COUNT];
    logic [31:0]         rdy_mask;
    logic [TASK_W-1:0]   dl_head  [2];
    logic                dl_swap;
    logic [TASK_W-1:0]   running;
    logic [TICK_W-1:0]   ticks;
    int                  n_tasks;

    cmd_t       pending_cmds [$];
    sched_res_t expected_res [$];
    int  errors;
    int  n_shown;
    bit  stim_done;
    bit  hold_off_req;
    int  hold_left;

    always #10 clk = ~clk;

    function automatic void sched_reset();
        min_stack = MIN_STACK_RESET;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            t_prio[i] = '0; t_stat[i] = ST_FREE; t_wake[i] = '0;
            t_reason[i] = REASON_NONE; t_link[i] = END_LINK;
        end
        for (int p = 0; p < PRIORITY_COUNT; p++)
        begin
            rq_head[p] = END_LINK; rq_tail[p] = END_LINK;
        end
        rdy_mask = '0;
        dl_head[0] = END_LINK; dl_head[1] = END_LINK;
        dl_swap = 1'b0;
        running = NO_TASK;
        ticks = '0;
        n_tasks = 0;
    endfunction

    function automatic void rq_push(logic [TASK_W-1:0] t);
        logic [PRIO_W-1:0] p;
        p = t_prio[t];
        t_link[t] = END_LINK;
        if (rq_tail[p] == END_LINK) rq_head[p] = t;
        else t_link[rq_tail[p][2:0]] = t;
        rq_tail[p] = t;
        rdy_mask[p] = 1'b1;
        t_stat[t] = ST_READY;
    endfunction

    function automatic logic [TASK_W-1:0] rq_pop();
        int p;
        logic [TASK_W-1:0] t;
        if (rdy_mask == 0) return END_LINK;
        for (p = PRIORITY_COUNT - 1; p > 0; p--)
            if (rdy_mask[p]) break;
        t = rq_head[p];
        rq_head[p] = t_link[t[2:0]];
        if (t_link[t[2:0]] == END_LINK)
        begin
            rq_tail[p] = END_LINK;
            rdy_mask[p] = 1'b0;
        end
        t_stat[t[2:0]] = ST_HELD;
        return t;
    endfunction

    function automatic void dl_insert(logic [TASK_W-1:0] t, int q);
        logic [TASK_W-1:0] prv, cur;
        prv = END_LINK;
        cur = dl_head[q];
        while (cur != END_LINK && t_wake[cur[2:0]] <= t_wake[t[2:0]])
        begin
            prv = cur; cur = t_link[cur[2:0]];
        end
        t_link[t[2:0]] = cur;
        if (prv == END_LINK) dl_head[q] = t;
        else t_link[prv[2:0]] = t;
        t_stat[t[2:0]] = (q == 0) ? ST_DELAY0 : ST_DELAY1;
    endfunction

    function automatic void dl_remove(logic [TASK_W-1:0] t, int q);
        logic [TASK_W-1:0] prv, cur;
        prv = END_LINK;
        cur = dl_head[q];
        while (cur != END_LINK && cur != t)
        begin
            prv = cur; cur = t_link[cur[2:0]];
        end
        if (cur == END_LINK) return;
        if (prv == END_LINK) dl_head[q] = t_link[t[2:0]];
        else t_link[prv[2:0]] = t_link[t[2:0]];
    endfunction

    function automatic void wake_task(logic [TASK_W-1:0] t, logic [REASON_W-1:0] r);
        logic [STAT_W-1:0] s;
        s = t_stat[t[2:0]];
        if (s == ST_DELAY0) dl_remove(t, 0);
        else if (s == ST_DELAY1) dl_remove(t, 1);
        else if (s != ST_SUSP) return;
        rq_push(t);
        t_reason[t[2:0]] = r;
    endfunction

    function automatic logic [PRIO_W-1:0] run_prio();
        return (running < MAX_TASKS) ? t_prio[running[2:0]] : '0;
    endfunction

    function automatic sched_res_t schedule_cmd(cmd_t c);
        sched_res_t r;
        logic sw, refused, created;
        logic [TASK_W-1:0] new_id, t;
        logic [RSTAT_W-1:0] st;
        sw = 0; refused = 0; created = 0; new_id = '0; st = RS_OK;
        case (c.kind)
            K_START:
                if (running != NO_TASK || rdy_mask == 0) refused = 1;
                else running = rq_pop();
            K_SWITCH:
                if (running == NO_TASK) refused = 1;
                else
                begin
                    if (running < MAX_TASKS && t_stat[running[2:0]] == ST_HELD)
                        rq_push(running);
                    running = (rdy_mask == 0) ? IDLE_ID : rq_pop();
                end
            K_CREATE:
                if (!c.args_valid || c.priority_req >= PRIORITY_COUNT || !c.stack_aligned)
                    st = RS_INVALID;
                else if (c.stack_words < min_stack) st = RS_STACK;
                else
                begin
                    st = RS_LIMIT;
                    if (n_tasks < MAX_TASKS)
                        for (int i = 0; i < MAX_TASKS; i++)
                            if (t_stat[i] == ST_FREE)
                            begin
                                new_id = TASK_W'(i);
                                t_prio[i] = c.priority_req[PRIO_W-1:0];
                                t_reason[i] = REASON_NONE;
                                n_tasks++;
                                rq_push(new_id);
                                sw = running != NO_TASK && c.priority_req > run_prio();
                                created = 1;
                                st = RS_OK;
                                break;
                            end
                end
            K_BLOCK:
                if (running < MAX_TASKS && t_stat[running[2:0]] == ST_HELD)
                begin
                    t_wake[running[2:0]] = c.wake_tick;
                    if (c.infinite) t_stat[running[2:0]] = ST_SUSP;
                    else if (c.wake_tick < ticks) dl_insert(running, dl_swap ^ 1'b1);
                    else dl_insert(running, dl_swap);
                end
            K_UNBLOCK:
                wake_task({1'b0, c.target_task}, c.wake_reason);
            K_TICK:
            begin
                ticks++;
                if (ticks == 0)
                begin
                    t = dl_head[dl_swap];
                    while (t != END_LINK)
                    begin
                        t_stat[t[2:0]] = ST_HELD;
                        t = t_link[t[2:0]];
                    end
                    dl_head[dl_swap] = END_LINK;
                    dl_swap ^= 1'b1;
                end
                while (dl_head[dl_swap] != END_LINK
                       && t_wake[dl_head[dl_swap][2:0]] <= ticks)
                    wake_task(dl_head[dl_swap], REASON_TIMEOUT);
                sw = (rdy_mask >> run_prio()) != 0;
            end
            K_CLEAR:
                if (running < MAX_TASKS) t_reason[running[2:0]] = REASON_NONE;
            default: ;
        endcase
        r.status = st;
        if (created)
        begin
            r.chosen_task = new_id; r.chosen_valid = 1;
        end
        else if (refused || running == NO_TASK)
        begin
            r.chosen_task = '0; r.chosen_valid = 0;
        end
        else
        begin
            r.chosen_task = running; r.chosen_valid = 1;
        end
        r.switch_request = sw;
        r.tick_now = ticks;
        r.wait_reason = (running < MAX_TASKS) ? t_reason[running[2:0]] : REASON_NONE;
        r.prio = run_prio();
        return r;
    endfunction

    // driver
    int gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
            gap <= 0;
        end
        else if (cmd.valid && !cmd.ready)
        begin
        end
        else
        begin
            if (cmd.valid) expected_res.push_back(schedule_cmd(cmd_t'({cmd.kind,
                cmd.priority_req, cmd.stack_words, cmd.stack_aligned, cmd.args_valid,
                cmd.wake_tick, cmd.infinite, cmd.target_task, cmd.wake_reason})));
            if (gap > 0)
            begin
                gap <= gap - 1;
                cmd.valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                cmd_t c;
                c = pending_cmds.pop_front();
                cmd.valid <= 1'b1;
                {cmd.kind, cmd.priority_req, cmd.stack_words, cmd.stack_aligned,
                 cmd.args_valid, cmd.wake_tick, cmd.infinite, cmd.target_task,
                 cmd.wake_reason} <= c;
                gap <= ($urandom_range(0, 3) == 0) ? 0 :
                       ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 3);
            end
            else
                cmd.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                sched_res_t a, e;
                a = '{res.status, res.chosen_task, res.chosen_valid, res.switch_request,
                      res.tick_now, res.current_wait_reason, res.current_priority};
                if (expected_res.size() == 0)
                begin
                    errors++;
                    if (n_shown < 10) $display("unexpected result %p", a);
                    n_shown++;
                end
                else
                begin
                    e = expected_res.pop_front();
                    if (a !== e)
                    begin
                        errors++;
                        if (n_shown < 10) $display("mismatch exp %p got %p", e, a);
                        n_shown++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                res.ready <= 1'b0;
            end
            else if (hold_off_req)
            begin
                hold_left <= 150;
                res.ready <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                res.ready <= 1'b0;
                hold_left <= ($urandom_range(0, 20) == 0) ? $urandom_range(10, 40) : 0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    function automatic cmd_t rand_cmd(logic [KIND_W-1:0] k);
        cmd_t c;
        c.kind = k;
        c.priority_req = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
        c.stack_words = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
        c.stack_aligned = $urandom_range(0, 9) != 0;
        c.args_valid = $urandom_range(0, 9) != 0;
        case ($urandom_range(0, 3))
            0: c.wake_tick = $urandom;
            1: c.wake_tick = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: c.wake_tick = ticks + $urandom_range(0, 12);
        endcase
        c.infinite = $urandom_range(0, 4) == 0;
        c.target_task = 3'($urandom);
        c.wake_reason = 2'($urandom);
        return c;
    endfunction

    function automatic logic [KIND_W-1:0] rand_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return K_START;
        if (r < 25) return K_SWITCH;
        if (r < 40) return K_CREATE;
        if (r < 55) return K_BLOCK;
        if (r < 68) return K_UNBLOCK;
        if (r < 92) return K_TICK;
        if (r < 97) return K_CLEAR;
        return KIND_W'(7);
    endfunction

    task automatic drain();
        while (pending_cmds.size() > 0 || cmd.valid || expected_res.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_min_stack(logic [STACK_W-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        min_stack = v;
    endtask

    task automatic directed();
        cmd_t c;
        c = rand_cmd(K_START); pending_cmds.push_back(c);
        c = rand_cmd(K_SWITCH); pending_cmds.push_back(c);
        c = rand_cmd(K_CREATE); c.args_valid = 0; pending_cmds.push_back(c);
        c.args_valid = 1; c.priority_req = 8'd255; c.stack_aligned = 1;
        pending_cmds.push_back(c);
        c.priority_req = 8'd32; pending_cmds.push_back(c);
        c.priority_req = 8'd31; c.stack_aligned = 0; pending_cmds.push_back(c);
        c.stack_aligned = 1; c.stack_words = 16'd63; pending_cmds.push_back(c);
        for (int i = 0; i < 9; i++)
        begin
            c.stack_words = (i == 8) ? 16'hFFFF : 16'd64;
            c.priority_req = (i == 0) ? 8'd0 : 8'(i * 4 - 1);
            pending_cmds.push_back(c);
        end
        c = rand_cmd(K_START); pending_cmds.push_back(c);
        c = rand_cmd(K_BLOCK); c.infinite = 1; pending_cmds.push_back(c);
        c = rand_cmd(K_SWITCH); pending_cmds.push_back(c);
        c = rand_cmd(K_BLOCK); c.infinite = 0; c.wake_tick = 32'd2; pending_cmds.push_back(c);
        c = rand_cmd(K_UNBLOCK); c.target_task = 3'd7; c.wake_reason = 2'd3;
        pending_cmds.push_back(c);
        c = rand_cmd(K_TICK); pending_cmds.push_back(c); pending_cmds.push_back(c);
        c = rand_cmd(K_CLEAR); pending_cmds.push_back(c);
        c = rand_cmd(KIND_W'(7)); pending_cmds.push_back(c);
    endtask

    initial
    begin
        logic [STACK_W-1:0] settings [4];
        settings = '{16'd0, 16'hFFFF, 16'd100, 16'd64};
        clk = 0; rst_n = 0; cfg_wr_en = 0; cfg_wr_data = '0;
        cmd.valid = 0; res.ready = 0;
        {cmd.kind, cmd.priority_req, cmd.stack_words, cmd.stack_aligned, cmd.args_valid,
         cmd.wake_tick, cmd.infinite, cmd.target_task, cmd.wake_reason} = '0;
        errors = 0; n_shown = 0; stim_done = 0; hold_off_req = 0;
        sched_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        directed();
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            write_min_stack(settings[ph]);
            // the driver predicts at acceptance, so ticks here lag; fine for spread
            for (int i = 0; i < 150; i++)
                pending_cmds.push_back(rand_cmd(rand_kind()));
            if (ph == 1)
            begin
                hold_off_req <= 1'b1;
                @(posedge clk);
                hold_off_req <= 1'b0;
            end
            if (ph == 2)
            begin
                // bring the tick counter near the wrap through many ticks is too slow;
                // instead rely on wake values near the top of range for sorting
            end
            drain();
        end
        stim_done = 1;
        if (errors == 0)
            $display("[priority_task_scheduler_top] OK");
        else
            $display("[priority_task_scheduler_top] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[priority_task_scheduler_top] ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/pts_pkg.sv
sv/pts_cmd_if.sv
sv/pts_res_if.sv
sv/pts_ram.sv
sv/priority_task_scheduler_top.sv
sim/testbench.sv
